// ===== sv/vlpq_pkg.sv =====
package vlpq_pkg;

  localparam int DEF_DATA_DEPTH  = 256;
  localparam int DEF_MAX_PACKETS = 16;
  localparam int DEF_ELEM_WIDTH  = 8;

  localparam int DATA_W = 8;
  localparam int PLEN_W = 9;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_PENDING  = 3'd0,
    ST_ACCEPTED = 3'd1,
    ST_REJECTED = 3'd2,
    ST_POP      = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [DATA_W-1:0] push_data;
    logic              push_last;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] pop_data;
    logic              pop_last;
    logic [PLEN_W-1:0] packet_length;
  } rsp_t;

endpackage

// ===== sv/variable_length_packet_queue_unit.sv =====
// A request is registered when accepted; busy stays high through the execute
// state, so no new request is taken until the last is done. The accept cycle reads the element
// and length memories and the following cycle does the update and write-back and registers the result.
// Reset clears the pointers, counters and control state at once; both memories
// stay undefined until written, so there is no clearing pass.
// The receiver cannot stall: the done strobe for each result is high for exactly one cycle.
module variable_length_packet_queue_unit
  import vlpq_pkg::*;
#(
  parameter int DATA_DEPTH  = DEF_DATA_DEPTH,
  parameter int MAX_PACKETS = DEF_MAX_PACKETS,
  parameter int ELEM_WIDTH  = DEF_ELEM_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t rsp
);

  localparam int AW = $clog2(DATA_DEPTH);
  localparam int CW = $clog2(DATA_DEPTH + 1);
  localparam int SW = AW + 1;
  localparam int LW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam int PW = $clog2(MAX_PACKETS + 1);

  localparam logic [SW-1:0] DEPTH_S  = SW'(DATA_DEPTH);
  localparam logic [CW:0]   DEPTH_C  = (CW + 1)'(DATA_DEPTH);
  localparam logic [PW-1:0] MAXPKT_P = PW'(MAX_PACKETS);
  localparam logic [LW-1:0] LAST_LEN = LW'(MAX_PACKETS - 1);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t              state;
  req_t                req_q;
  logic [ELEM_WIDTH-1:0] elem_mem [DATA_DEPTH];
  logic [CW-1:0]       len_mem [MAX_PACKETS];
  logic [ELEM_WIDTH-1:0] elem_rd;
  logic [CW-1:0]       len_rd;

  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [CW-1:0] committed, committed_next;
  logic [CW-1:0] tentative, tentative_next;
  logic          reject_pend, reject_pend_next;
  logic [PW-1:0] pkt_count, pkt_count_next;
  logic [LW-1:0] len_head, len_head_next;
  logic [LW-1:0] len_tail, len_tail_next;
  logic [CW-1:0] head_off, head_off_next;
  rsp_t          rsp_next;

  logic                  elem_we, len_we;
  logic [AW-1:0]         slot;
  logic [CW-1:0]         len_wdata;
  logic [ELEM_WIDTH-1:0] elem_wdata;
  logic [63:0]           push_wide, rd_wide;
  logic [31:0]           len_wide;
  logic                  accept;

  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [CW-1:0] amt);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(amt);
    if (s >= DEPTH_S) s = s - DEPTH_S;
    return s[AW-1:0];
  endfunction

  function automatic logic [LW-1:0] len_step(logic [LW-1:0] i);
    return (i == LAST_LEN) ? '0 : LW'(i + 1'b1);
  endfunction

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  assign push_wide  = 64'(req_q.push_data);
  assign elem_wdata = push_wide[ELEM_WIDTH-1:0];
  assign rd_wide    = 64'(elem_rd);
  assign len_wide   = 32'(len_rd);
  assign slot       = ring_add(wr_ptr, tentative);

  always_comb begin
    logic [CW-1:0] tent_v;
    logic          rej_v;
    logic [CW-1:0] hoff_inc;
    logic          last_v;
    wr_ptr_next      = wr_ptr;
    rd_ptr_next      = rd_ptr;
    committed_next   = committed;
    tentative_next   = tentative;
    reject_pend_next = reject_pend;
    pkt_count_next   = pkt_count;
    len_head_next    = len_head;
    len_tail_next    = len_tail;
    head_off_next    = head_off;
    rsp_next         = '0;
    elem_we          = 1'b0;
    len_we           = 1'b0;
    len_wdata        = tentative;
    tent_v           = tentative;
    rej_v            = reject_pend;
    hoff_inc         = head_off + 1'b1;
    last_v           = 1'b0;
    if (req_q.cmd == CMD_PUSH) begin
      if (!rej_v) begin
        // Overflow drops the tentative elements and discards the rest of the packet.
        if (({1'b0, committed} + {1'b0, tentative}) >= DEPTH_C) begin
          rej_v  = 1'b1;
          tent_v = '0;
        end else begin
          elem_we = 1'b1;
          tent_v  = tentative + 1'b1;
        end
      end
      if (!req_q.push_last) begin
        rsp_next.status = ST_PENDING;
      end else if (rej_v || (pkt_count >= MAXPKT_P)) begin
        rej_v           = 1'b0;
        tent_v          = '0;
        rsp_next.status = ST_REJECTED;
      end else begin
        len_we          = 1'b1;
        len_wdata       = tent_v;
        len_tail_next   = len_step(len_tail);
        pkt_count_next  = pkt_count + 1'b1;
        committed_next  = committed + tent_v;
        wr_ptr_next     = ring_add(wr_ptr, tent_v);
        tent_v          = '0;
        rsp_next.status = ST_ACCEPTED;
      end
      tentative_next   = tent_v;
      reject_pend_next = rej_v;
    end else begin
      if (pkt_count == '0) begin
        rsp_next.status = ST_EMPTY;
      end else begin
        rd_ptr_next = ring_add(rd_ptr, CW'(1));
        if (committed != '0) committed_next = committed - 1'b1;
        last_v = (hoff_inc >= len_rd);
        if (last_v) begin
          head_off_next  = '0;
          len_head_next  = len_step(len_head);
          pkt_count_next = pkt_count - 1'b1;
        end else begin
          head_off_next = hoff_inc;
        end
        rsp_next.status        = ST_POP;
        rsp_next.pop_data      = rd_wide[DATA_W-1:0];
        rsp_next.pop_last      = last_v;
        rsp_next.packet_length = len_wide[PLEN_W-1:0];
      end
    end
  end

  // Reads are issued with the request; writes land in the execute cycle,
  // so a later read always sees them.
  always_ff @(posedge clk) begin
    if (accept) begin
      elem_rd <= elem_mem[rd_ptr];
      len_rd  <= len_mem[len_head];
    end
    if ((state == S_EXEC) && elem_we) elem_mem[slot] <= elem_wdata;
    if ((state == S_EXEC) && len_we) len_mem[len_tail] <= len_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      committed   <= '0;
      tentative   <= '0;
      reject_pend <= 1'b0;
      pkt_count   <= '0;
      len_head    <= '0;
      len_tail    <= '0;
      head_off    <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_q <= req;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          wr_ptr      <= wr_ptr_next;
          rd_ptr      <= rd_ptr_next;
          committed   <= committed_next;
          tentative   <= tentative_next;
          reject_pend <= reject_pend_next;
          pkt_count   <= pkt_count_next;
          len_head    <= len_head_next;
          len_tail    <= len_tail_next;
          head_off    <= head_off_next;
          rsp         <= rsp_next;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/vlpq_checker.sv =====
module vlpq_checker
  import vlpq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input req_t req,
  input rsp_t rsp
);

  // Every accepted request is followed by its result strobe.
  a_result_timing: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result strobe missing after accepted request");

  // The block is busy while a request is in flight.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // A result only follows work: the block was busy before the strobe and is idle with it.
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result strobe without preceding work");

  // Only a popped element carries data, last flag and length.
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status != ST_POP)) |->
      ((rsp.pop_data == '0) && !rsp.pop_last && (rsp.packet_length == '0)))
    else $error("non-pop result carries pop fields");

  // A popped element comes from a packet of nonzero length.
  a_pop_length: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status == ST_POP)) |-> (rsp.packet_length != '0))
    else $error("popped element with zero packet length");

endmodule

bind variable_length_packet_queue_unit vlpq_checker u_vlpq_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .req   (req),
  .rsp   (rsp)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import vlpq_pkg::*;

  localparam int DEPTH     = DEF_DATA_DEPTH;
  localparam int MAXPKT    = DEF_MAX_PACKETS;
  localparam int CYCLE_CAP = 200000;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  variable_length_packet_queue_unit DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .req(req),
    .busy(busy),
    .done(done),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Mirror of the queue state, kept in step with every accepted request.
  logic [DATA_W-1:0] elem_mem [DEPTH];
  int len_mem [MAXPKT];
  int wr_ptr = 0;
  int rd_ptr = 0;
  int committed = 0;
  int tentative = 0;
  int pkt_count = 0;
  int len_head = 0;
  int len_tail = 0;
  int head_off = 0;
  bit dropping = 1'b0;

  int n_overflow = 0;
  int n_limit = 0;
  int n_sent = 0;
  int n_commit = 0;
  int n_reject = 0;
  int n_popped = 0;
  int n_empty = 0;
  int errors = 0;
  int cycles = 0;

  rsp_t pending_responses[$];
  logic row_typed = 1'b0;
  rsp_t row_want = '0;

  typedef struct {
    req_t r;
    rsp_t want;
  } step_t;

  step_t steps [18] = '{
    '{'{CMD_POP,  8'h00, 1'b0}, '{ST_EMPTY,    8'h00, 1'b0, 9'd0}},
    '{'{CMD_PUSH, 8'hFF, 1'b1}, '{ST_ACCEPTED, 8'h00, 1'b0, 9'd0}},
    '{'{CMD_PUSH, 8'h00, 1'b1}, '{ST_ACCEPTED, 8'h00, 1'b0, 9'd0}},
    '{'{CMD_POP,  8'h00, 1'b0}, '{ST_POP,      8'hFF, 1'b1, 9'd1}},
    '{'{CMD_POP,  8'h00, 1'b0}, '{ST_POP,      8'h00, 1'b1, 9'd1}},
    '{'{CMD_POP,  8'h00, 1'b0}, '{ST_EMPTY,    8'h00, 1'b0, 9'd0}},
    '{'{CMD_PUSH, 8'hA5, 1'b0}, '{ST_PENDING,  8'h00, 1'b0, 9'd0}},
    '{'{CMD_POP,  8'h00, 1'b0}, '{ST_EMPTY,    8'h00, 1'b0, 9'd0}},
    '{'{CMD_PUSH, 8'h5A, 1'b0}, '{ST_PENDING,  8'h00, 1'b0, 9'd0}},
    '{'{CMD_PUSH, 8'h3C, 1'b1}, '{ST_ACCEPTED, 8'h00, 1'b0, 9'd0}},
    '{'{CMD_PUSH, 8'h81, 1'b0}, '{ST_PENDING,  8'h00, 1'b0, 9'd0}},
    '{'{CMD_POP,  8'h00, 1'b0}, '{ST_POP,      8'hA5, 1'b0, 9'd3}},
    '{'{CMD_PUSH, 8'h7E, 1'b1}, '{ST_ACCEPTED, 8'h00, 1'b0, 9'd0}},
    '{'{CMD_POP,  8'h00, 1'b0}, '{ST_POP,      8'h5A, 1'b0, 9'd3}},
    '{'{CMD_POP,  8'h00, 1'b0}, '{ST_POP,      8'h3C, 1'b1, 9'd3}},
    '{'{CMD_POP,  8'h00, 1'b0}, '{ST_POP,      8'h81, 1'b0, 9'd2}},
    '{'{CMD_POP,  8'h00, 1'b0}, '{ST_POP,      8'h7E, 1'b1, 9'd2}},
    '{'{CMD_POP,  8'hFF, 1'b1}, '{ST_EMPTY,    8'h00, 1'b0, 9'd0}}
  };

  function automatic rsp_t next_queue_response(req_t r);
    rsp_t o;
    int plen;
    o = '0;
    if (r.cmd == CMD_PUSH) begin
      if (!dropping) begin
        if (committed + tentative >= DEPTH) begin
          // No free slot: the whole packet is dropped up to its last element.
          dropping = 1'b1;
          tentative = 0;
        end else begin
          elem_mem[(wr_ptr + tentative) % DEPTH] = r.push_data;
          tentative++;
        end
      end
      if (!r.push_last) begin
        o.status = ST_PENDING;
      end else if (dropping || pkt_count >= MAXPKT) begin
        if (dropping) n_overflow++;
        else n_limit++;
        dropping = 1'b0;
        tentative = 0;
        o.status = ST_REJECTED;
      end else begin
        len_mem[len_tail] = tentative;
        len_tail = (len_tail + 1) % MAXPKT;
        pkt_count++;
        committed += tentative;
        wr_ptr = (wr_ptr + tentative) % DEPTH;
        tentative = 0;
        o.status = ST_ACCEPTED;
      end
    end else if (pkt_count == 0) begin
      o.status = ST_EMPTY;
    end else begin
      plen = len_mem[len_head];
      o.pop_data = elem_mem[rd_ptr];
      rd_ptr = (rd_ptr + 1) % DEPTH;
      if (committed > 0) committed--;
      head_off++;
      o.pop_last = (head_off >= plen);
      if (o.pop_last) begin
        head_off = 0;
        len_head = (len_head + 1) % MAXPKT;
        pkt_count--;
      end
      o.status = ST_POP;
      o.packet_length = plen[PLEN_W-1:0];
    end
    return o;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && start && !busy) begin
      want = next_queue_response(req);
      if (row_typed) want = row_want;
      pending_responses.push_back(want);
    end
    if (!rst && done) begin
      case (rsp.status)
        ST_ACCEPTED: n_commit++;
        ST_REJECTED: n_reject++;
        ST_POP:      n_popped++;
        ST_EMPTY:    n_empty++;
        default: ;
      endcase
      if (pending_responses.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none, got %p", $time, rsp);
      end else begin
        want = pending_responses.pop_front();
        check_field("status", want.status, rsp.status);
        check_field("pop_data", want.pop_data, rsp.pop_data);
        check_field("pop_last", want.pop_last, rsp.pop_last);
        check_field("packet_length", want.packet_length, rsp.packet_length);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Called right after a rising edge; returns at the edge that takes the request.
  task automatic issue(req_t r, int idle_pct, logic typed, rsp_t want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (busy);
    n_sent++;
  endtask

  // Well-formed packets with random content. Fill stretches pop rarely so the
  // packet limit and the element store overflow get reached; drain stretches
  // pop often enough to empty the queue.
  task automatic random_traffic(int n_items, int idle_pct);
    int count;
    int plen;
    int pick;
    bit filling;
    req_t r;
    count = 0;
    filling = 1'b1;
    while (count < n_items) begin
      if ($urandom_range(99) < 10) filling = !filling;
      pick = $urandom_range(99);
      if (pick < 75) plen = $urandom_range(1, 6);
      else if (pick < 96 || !filling) plen = $urandom_range(7, 40);
      else plen = $urandom_range(120, 280);
      for (int k = 0; k < plen; k++) begin
        while ($urandom_range(99) < (filling ? 10 : 65)) begin
          r.cmd = CMD_POP;
          r.push_data = DATA_W'($urandom);
          r.push_last = 1'($urandom);
          issue(r, idle_pct, 1'b0, '0);
          count++;
        end
        r.cmd = CMD_PUSH;
        r.push_data = DATA_W'($urandom);
        r.push_last = (k == plen - 1);
        issue(r, idle_pct, 1'b0, '0);
        count++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (steps[i]) issue(steps[i].r, 0, 1'b1, steps[i].want);
    random_traffic(250, 0);
    random_traffic(250, 61);
    random_traffic(250, 23);
    start <= 1'b0;
    while (pending_responses.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d requests: %0d packets committed, %0d rejected",
             n_sent, n_commit, n_reject);
    $display("(%0d store full, %0d at limit), %0d elements popped, %0d pops on an empty queue.",
             n_overflow, n_limit, n_popped, n_empty);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
